>>> hdl/mclp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared constants and types of the motor command line parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int LINE_BUFFER_SIZE_DEF = 512;

  localparam int TOKENS     = 4;
  localparam int PREFIX_LEN = 18;

  localparam logic [13:0] VALUE_SAT = 14'd10000;
  localparam logic [13:0] VALUE_MAX = 14'd9999;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef struct packed {
    logic stop;
    logic neg;
    logic started;
  } tok_flags_t;

  function automatic logic [7:0] head_char(input logic [4:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = "d";
      5'd1:    ch = "e";
      5'd2:    ch = "v";
      5'd3:    ch = "i";
      5'd4:    ch = "c";
      5'd5:    ch = "e";
      5'd6:    ch = " ";
      5'd7:    ch = "m";
      5'd8:    ch = "o";
      5'd9:    ch = "t";
      5'd10:   ch = "o";
      5'd11:   ch = "r";
      5'd12:   ch = " ";
      5'd13:   ch = "p";
      5'd14:   ch = "u";
      5'd15:   ch = "s";
      5'd16:   ch = "h";
      5'd17:   ch = "=";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

>>> hdl/motor_command_line_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_line_parser
// Parses "device motor push=time,wait,duty[,accel]" lines from a byte stream
// and gives one checked command for each non-empty line.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  input    in_valid/in_stall   rx_byte
//  output   out_valid/out_stall command_ok, run_time_ms, pause_time_ms,
//                               duty_percent, accel_step
//
// Each byte is parsed while it sits in the input register, and the command is
// registered as its line end leaves that register. One byte is taken every
// cycle unless a stalled output holds back a line end; it holds back no other bytes.
// Reset clears all line state; no clearing pass is needed.
module motor_command_line_parser #(
  parameter int LINE_BUFFER_SIZE = mclp_pkg::LINE_BUFFER_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             command_ok,
  output logic [13:0]      run_time_ms,
  output logic [13:0]      pause_time_ms,
  output logic [6:0]       duty_percent,
  output logic [5:0]       accel_step
);
  import mclp_pkg::*;

  localparam int CW = $clog2(LINE_BUFFER_SIZE);
  localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_BUFFER_SIZE - 1);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_TOKEN  = 3'd3;
  localparam logic [2:0] PH_REJECT = 3'd4;

  logic             s1_valid;
  logic [7:0]       s1_byte;

  logic [CW-1:0]    stored_count, stored_count_next;
  logic [4:0]       prefix_position, prefix_position_next;
  logic [2:0]       line_phase, line_phase_next;
  logic [2:0]       token_index, token_index_next;
  logic             token_blank_only, token_blank_only_next;
  logic [13:0]      token_values [TOKENS];
  tok_flags_t       token_flags [TOKENS];

  logic             is_eol, printable, produce, advance, feed_en;
  logic [2:0]       eff_phase, slot_full;
  logic [1:0]       slot;
  logic [7:0]       lower;
  tok_flags_t       feed_flags, feed_flags_out;
  logic [13:0]      feed_value, feed_value_out;

  logic [2:0]       n;
  logic [13:0]      t_val, w_val, d_val, a_val;
  logic             ok;

  function automatic logic [13:0] tok_result(input tok_flags_t f, input logic [13:0] v);
    return (f.neg && v != 14'd0) ? VALUE_SAT : v;
  endfunction

  assign is_eol    = (s1_byte == CH_CR) || (s1_byte == CH_LF);
  assign printable = (s1_byte >= CH_SPACE) && (s1_byte < CH_DEL);
  assign produce   = is_eol && (stored_count != '0);
  assign advance   = s1_valid && (!produce || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;

  assign lower = (s1_byte >= 8'h41 && s1_byte <= 8'h5A) ? s1_byte + 8'h20 : s1_byte;
  assign eff_phase = (line_phase == PH_LEAD && s1_byte != CH_SPACE) ? PH_PREFIX : line_phase;

  assign slot_full  = (line_phase == PH_GAP) ? token_index : token_index - 3'd1;
  assign slot       = slot_full[1:0];
  assign feed_flags = (line_phase == PH_GAP) ? tok_flags_t'('0) : token_flags[slot];
  assign feed_value = (line_phase == PH_GAP) ? 14'd0 : token_values[slot];

  mclp_digit u_digit (
    .ch         (s1_byte),
    .flags      (feed_flags),
    .value      (feed_value),
    .flags_next (feed_flags_out),
    .value_next (feed_value_out)
  );

  always_comb begin
    stored_count_next     = stored_count;
    prefix_position_next  = prefix_position;
    line_phase_next       = line_phase;
    token_index_next      = token_index;
    token_blank_only_next = token_blank_only;
    feed_en               = 1'b0;
    if (advance && !is_eol && printable && stored_count < COUNT_MAX) begin
      stored_count_next = stored_count + 1'b1;
      case (eff_phase)
        PH_PREFIX: begin
          if (prefix_position >= 5'(PREFIX_LEN) || lower != head_char(prefix_position)) begin
            line_phase_next = PH_REJECT;
          end else begin
            prefix_position_next = prefix_position + 5'd1;
            line_phase_next = (prefix_position == 5'(PREFIX_LEN - 1)) ? PH_GAP : PH_PREFIX;
          end
        end
        PH_GAP: begin
          if (s1_byte != CH_COMMA) begin
            if (token_index < 3'd7) begin
              token_index_next = token_index + 3'd1;
            end
            token_blank_only_next = (s1_byte == CH_SPACE);
            line_phase_next = PH_TOKEN;
            feed_en = (token_index < 3'(TOKENS));
          end
        end
        PH_TOKEN: begin
          if (s1_byte == CH_COMMA) begin
            line_phase_next = PH_GAP;
          end else begin
            if (s1_byte != CH_SPACE) begin
              token_blank_only_next = 1'b0;
            end
            feed_en = (slot_full < 3'(TOKENS));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    n = token_index;
    if (line_phase == PH_TOKEN && token_blank_only && n != 3'd0) begin
      n = n - 3'd1;
    end
    t_val = tok_result(token_flags[0], token_values[0]);
    w_val = tok_result(token_flags[1], token_values[1]);
    d_val = tok_result(token_flags[2], token_values[2]);
    a_val = (n >= 3'd4) ? tok_result(token_flags[3], token_values[3]) : 14'd0;
    ok = (line_phase == PH_GAP || line_phase == PH_TOKEN) && n >= 3'd3 &&
         t_val >= 14'd1 && t_val <= VALUE_MAX && w_val <= VALUE_MAX &&
         d_val >= 14'd5 && d_val <= 14'd100 && a_val <= 14'd50;
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= rx_byte;
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && is_eol)) begin
      stored_count     <= '0;
      prefix_position  <= '0;
      line_phase       <= PH_LEAD;
      token_index      <= '0;
      token_blank_only <= 1'b0;
      for (int i = 0; i < TOKENS; i++) begin
        token_values[i] <= '0;
        token_flags[i]  <= '0;
      end
    end else begin
      stored_count     <= stored_count_next;
      prefix_position  <= prefix_position_next;
      line_phase       <= line_phase_next;
      token_index      <= token_index_next;
      token_blank_only <= token_blank_only_next;
      if (feed_en) begin
        token_values[slot] <= feed_value_out;
        token_flags[slot]  <= feed_flags_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && produce) begin
      command_ok    <= ok;
      run_time_ms   <= ok ? t_val : 14'd0;
      pause_time_ms <= ok ? w_val : 14'd0;
      duty_percent  <= ok ? ((d_val > 14'd95) ? 7'd95 : d_val[6:0]) : 7'd0;
      accel_step    <= ok ? a_val[5:0] : 6'd0;
    end
  end

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !command_ok |-> run_time_ms == 14'd0 && pause_time_ms == 14'd0 &&
                                 duty_percent == 7'd0 && accel_step == 6'd0)
    else $error("failed command carries nonzero fields");

  a_ok_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && command_ok |-> run_time_ms >= 14'd1 && run_time_ms <= VALUE_MAX &&
                                duty_percent >= 7'd5 && duty_percent <= 7'd95 &&
                                accel_step <= 6'd50)
    else $error("accepted command out of range");

  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    stored_count <= COUNT_MAX)
    else $error("line byte count past its limit");

  a_token_started : assert property (@(posedge clk) disable iff (rst)
    line_phase == PH_TOKEN |-> token_index != 3'd0)
    else $error("inside a token with no token counted");

endmodule
`default_nettype wire

>>> hdl/mclp_digit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mclp_digit
// Takes one character into a numeric token: sign, digits and the stop point.
// ----------------------------------------------------------------------------
module mclp_digit (
  input  wire logic [7:0]           ch,
  input  wire mclp_pkg::tok_flags_t flags,
  input  wire logic [13:0]          value,
  output mclp_pkg::tok_flags_t      flags_next,
  output logic [13:0]               value_next
);
  import mclp_pkg::*;

  logic        digit;
  logic [16:0] grown;

  assign digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign grown = {value, 3'b000} + {2'b00, value, 1'b0} + {13'd0, ch[3:0]};

  always_comb begin
    flags_next = flags;
    value_next = value;
    if (!flags.stop) begin
      if (!flags.started) begin
        if (ch != CH_SPACE) begin
          flags_next.started = 1'b1;
          if (ch == CH_MINUS) begin
            flags_next.neg = 1'b1;
          end else if (ch != CH_PLUS && !digit) begin
            flags_next.stop = 1'b1;
          end
        end
      end else if (!digit) begin
        flags_next.stop = 1'b1;
      end
    end
    if (digit && !flags_next.stop) begin
      value_next = (grown > {3'b000, VALUE_SAT}) ? VALUE_SAT : grown[13:0];
    end
  end

endmodule
`default_nettype wire

>>> test/tb_motor_command_line_parser.sv
// ----------------------------------------------------------------------------
// tb_motor_command_line_parser
// Self-checking bench for the motor command line parser. Characters are fed
// one per item, and every command that comes out is compared with one that a
// parser in the bench predicts. The run covers directed lines, a very long
// line, dropped bytes, a long output hold and random lines with idle cycles
// on both channels.
// ----------------------------------------------------------------------------
module tb_motor_command_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import mclp_pkg::*;

  localparam int LINE_KEEP   = LINE_BUFFER_SIZE_DEF - 1;
  localparam int TIME_MIN    = 1;
  localparam int DUTY_MIN    = 5;
  localparam int DUTY_TOP    = 100;
  localparam int DUTY_CLAMP  = 95;
  localparam int ACCEL_MAX   = 50;
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 120;
  localparam int RANDOM_CMDS  = 4;
  localparam logic [8*PREFIX_LEN-1:0] HEAD_TEXT = "device motor push=";

  typedef enum logic [2:0] {
    LN_LEAD,
    LN_HEAD,
    LN_BETWEEN,
    LN_TOKEN,
    LN_BAD
  } line_state_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] run;
    logic [13:0] pause;
    logic [6:0]  duty;
    logic [5:0]  accel;
  } motor_cmd_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall;
  logic        command_ok;
  logic [13:0] run_time_ms;
  logic [13:0] pause_time_ms;
  logic [6:0]  duty_percent;
  logic [5:0]  accel_step;

  motor_cmd_t  cmd_expected[$];
  int          fail_count = 0;
  int          cmds_seen = 0;
  bit          idle_on = 1'b1;
  bit          hold_go = 1'b0;

  int          line_len;
  int          head_pos;
  line_state_t line_state;
  int          tok_count;
  logic [13:0] tok_val [TOKENS];
  tok_flags_t  tok_fl [TOKENS];
  logic        tok_blank;

  motor_command_line_parser dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .command_ok   (command_ok),
    .run_time_ms  (run_time_ms),
    .pause_time_ms(pause_time_ms),
    .duty_percent (duty_percent),
    .accel_step   (accel_step)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("motor_command_line_parser: mismatch");
    $finish;
  end

  task automatic clear_line();
    line_len = 0;
    head_pos = 0;
    line_state = LN_LEAD;
    tok_count = 0;
    tok_blank = 1'b0;
    for (int i = 0; i < TOKENS; i++) begin
      tok_val[i] = '0;
      tok_fl[i] = '0;
    end
  endtask

  task automatic feed_token_char(input int slot, input logic [7:0] ch);
    tok_flags_t f;
    logic       is_digit;
    int         v;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (ch != CH_SPACE) tok_blank = 1'b0;
    if (slot >= TOKENS) return;
    f = tok_fl[slot];
    if (f.stop) return;
    if (!f.started) begin
      if (ch == CH_SPACE) return;
      f.started = 1'b1;
      if (ch == CH_MINUS) f.neg = 1'b1;
      else if (ch != CH_PLUS && !is_digit) f.stop = 1'b1;
    end else if (!is_digit) begin
      f.stop = 1'b1;
    end
    if (is_digit && !f.stop) begin
      v = int'(tok_val[slot]) * 10 + int'(ch - CH_ZERO);
      tok_val[slot] = (v > int'(VALUE_SAT)) ? VALUE_SAT : v[13:0];
    end
    tok_fl[slot] = f;
  endtask

  function automatic int token_level(input int slot);
    if (tok_fl[slot].neg && tok_val[slot] != 0) return int'(VALUE_SAT);
    return int'(tok_val[slot]);
  endfunction

  // Updates the predicted line state with one accepted character.
  task automatic parse_char(input logic [7:0] ch);
    motor_cmd_t cmd;
    int         n, t, w, d, a;
    logic [7:0] lc;
    if (ch == CH_CR || ch == CH_LF) begin
      if (line_len == 0) return;
      cmd = '0;
      n = 0;
      if (line_state == LN_BETWEEN || line_state == LN_TOKEN) begin
        n = tok_count;
        if (line_state == LN_TOKEN && tok_blank && n > 0) n--;
        if (n > TOKENS) n = TOKENS;
      end
      if (n >= 3) begin
        t = token_level(0);
        w = token_level(1);
        d = token_level(2);
        a = (n >= 4) ? token_level(3) : 0;
        if (t >= TIME_MIN && t <= int'(VALUE_MAX) && w <= int'(VALUE_MAX) &&
            d >= DUTY_MIN && d <= DUTY_TOP && a <= ACCEL_MAX) begin
          if (d > DUTY_CLAMP) d = DUTY_CLAMP;
          cmd.ok = 1'b1;
          cmd.run = t[13:0];
          cmd.pause = w[13:0];
          cmd.duty = d[6:0];
          cmd.accel = a[5:0];
        end
      end
      cmd_expected.push_back(cmd);
      clear_line();
      return;
    end
    if (ch < CH_SPACE || ch >= CH_DEL) return;
    if (line_len >= LINE_KEEP) return;
    line_len++;
    if (line_state == LN_LEAD) begin
      if (ch == CH_SPACE) return;
      line_state = LN_HEAD;
    end
    case (line_state)
      LN_HEAD: begin
        lc = (ch >= "A" && ch <= "Z") ? ch + 8'h20 : ch;
        if (head_pos >= PREFIX_LEN ||
            lc != HEAD_TEXT[8*(PREFIX_LEN-1-head_pos) +: 8]) begin
          line_state = LN_BAD;
        end else begin
          head_pos++;
          if (head_pos == PREFIX_LEN) line_state = LN_BETWEEN;
        end
      end
      LN_BETWEEN: begin
        if (ch != CH_COMMA) begin
          if (tok_count < TOKENS) begin
            tok_val[tok_count] = '0;
            tok_fl[tok_count] = '0;
          end
          if (tok_count < 7) tok_count++;
          tok_blank = 1'b1;
          line_state = LN_TOKEN;
          feed_token_char(tok_count - 1, ch);
        end
      end
      LN_TOKEN: begin
        if (ch == CH_COMMA) line_state = LN_BETWEEN;
        else feed_token_char(tok_count - 1, ch);
      end
      default: ;
    endcase
  endtask

  task automatic send_char(input logic [7:0] ch);
    if (idle_on) begin
      while ($urandom_range(99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte <= ch;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_char(ch);
  endtask

  task automatic send_line(input string body, input logic [7:0] term);
    for (int i = 0; i < body.len(); i++) send_char(body[i]);
    send_char(term);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cmd_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_cmd
    motor_cmd_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (cmd_expected.size() == 0) begin
        $error("unexpected command: ok=%0d run=%0d pause=%0d duty=%0d accel=%0d",
               command_ok, run_time_ms, pause_time_ms, duty_percent, accel_step);
        fail_count++;
      end else begin
        want = cmd_expected.pop_front();
        cmds_seen++;
        if (command_ok !== want.ok) begin
          $error("command_ok: expected %0d, got %0d", want.ok, command_ok);
          fail_count++;
        end
        if (run_time_ms !== want.run) begin
          $error("run_time_ms: expected %0d, got %0d", want.run, run_time_ms);
          fail_count++;
        end
        if (pause_time_ms !== want.pause) begin
          $error("pause_time_ms: expected %0d, got %0d", want.pause, pause_time_ms);
          fail_count++;
        end
        if (duty_percent !== want.duty) begin
          $error("duty_percent: expected %0d, got %0d", want.duty, duty_percent);
          fail_count++;
        end
        if (accel_step !== want.accel) begin
          $error("accel_step: expected %0d, got %0d", want.accel, accel_step);
          fail_count++;
        end
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= idle_on && ($urandom_range(99) < 26);
    end
  end

  task automatic test_directed_lines();
    send_line("device motor push=100,200,50", CH_CR);
    send_line("  DEVICE Motor PUSH=1,0,5  ", CH_LF);
    send_line("device motor push=9999,9999,100,50", CH_CR);
    send_line("device motor push=0,10,50", CH_LF);
    send_line("device motor push=10000,10,50", CH_LF);
    send_line("device motor push=123456789,1,50", CH_LF);
    send_line("device motor push=10,10000,50", CH_LF);
    send_line("device motor push=10,10,4", CH_LF);
    send_line("device motor push=10,10,101", CH_LF);
    send_line("device motor push=10,10,50,51", CH_LF);
    send_line("device motor push=-5,10,50", CH_LF);
    send_line("device motor push=+7, -0 ,  0050 ,+0", CH_CR);
    send_line("device motor push=,,10,,20,,30,,", CH_LF);
    send_line("device motor push=10,20,30,   ", CH_LF);
    send_line("device motor push=10,20,   ", CH_LF);
    send_line("device motor push=1,2,30,4,999,abc", CH_LF);
    send_line("device motor push=1,2,30,4,5,6,7,8,9", CH_CR);
    send_line("device motor push=10,20", CH_LF);
    send_line("device motor push=", CH_LF);
    send_line("device motor pull=1,2,30", CH_LF);
    send_line("device motor push=12x,3 4,5z6", CH_LF);
    send_line("device motor push=-,+,7", CH_LF);
    send_char(CH_CR);
    send_line("    ", CH_LF);
  endtask

  task automatic test_dropped_bytes();
    send_line("device", 8'h00);
    send_char(8'h01);
    send_char(8'h1F);
    send_char(CH_DEL);
    send_char(8'h80);
    send_char(8'hFF);
    send_char(8'hAA);
    send_line(" motor push=5,6,7", CH_CR);
    send_char(8'h93);
    send_char(CH_LF);
  endtask

  task automatic test_long_line();
    string head = "device motor push=10,20,";
    idle_on = 1'b0;
    for (int i = 0; i < head.len(); i++) send_char(head[i]);
    repeat (LINE_KEEP - head.len() - 1) send_char(CH_ZERO);
    send_line("795", CH_LF);
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_go = 1'b1;
    for (int i = 0; i < 4; i++) begin
      send_line($sformatf("device motor push=%0d,%0d,%0d", i + 1, i * 10, i + 5), CH_LF);
    end
    wait_drained();
  endtask

  function automatic int pick_value(input int slot);
    int r;
    r = $urandom_range(9);
    if (r == 9) return $urandom_range(999999);
    if (r == 8) return $urandom_range(120);
    case (slot)
      0: return $urandom_range(9999, 1);
      1: return $urandom_range(9999);
      2: return $urandom_range(DUTY_TOP, DUTY_MIN);
      default: return $urandom_range(ACCEL_MAX);
    endcase
  endfunction

  task automatic random_line(inout int taken);
    logic [7:0] line_bytes[$];
    logic [7:0] ch;
    string      digits;
    int         kind, ntok, r;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(40, 1)) line_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 12) begin
      repeat ($urandom_range(3)) line_bytes.push_back(CH_SPACE);
    end else begin
      repeat ($urandom_range(3)) line_bytes.push_back(CH_SPACE);
      for (int i = 0; i < PREFIX_LEN; i++) begin
        ch = HEAD_TEXT[8*(PREFIX_LEN-1-i) +: 8];
        if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch - 8'h20;
        line_bytes.push_back(ch);
      end
      ntok = ($urandom_range(9) < 7) ? $urandom_range(4, 3) : $urandom_range(6);
      for (int i = 0; i < ntok; i++) begin
        if (i > 0) begin
          line_bytes.push_back(CH_COMMA);
          if ($urandom_range(9) == 0) line_bytes.push_back(CH_COMMA);
        end
        if ($urandom_range(7) == 0) line_bytes.push_back(CH_SPACE);
        r = $urandom_range(19);
        if (r == 0) line_bytes.push_back(CH_MINUS);
        else if (r == 1) line_bytes.push_back(CH_PLUS);
        if ($urandom_range(9) == 0) line_bytes.push_back(CH_ZERO);
        digits = $sformatf("%0d", pick_value(i));
        for (int j = 0; j < digits.len(); j++) line_bytes.push_back(digits[j]);
        if ($urandom_range(11) == 0) begin
          line_bytes.push_back(8'($urandom_range(8'h7E, CH_SPACE)));
        end
      end
      if ($urandom_range(7) == 0) line_bytes.push_back(CH_COMMA);
      repeat ($urandom_range(2)) line_bytes.push_back(CH_SPACE);
      if (kind < 24) begin
        line_bytes[$urandom_range(line_bytes.size() - 1)] = 8'($urandom_range(255));
      end
    end
    line_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
    foreach (line_bytes[i]) begin
      ch = line_bytes[i];
      send_char(ch);
      if (ch == CH_CR || ch == CH_LF || (ch >= CH_SPACE && ch < CH_DEL)) taken++;
    end
  endtask

  task automatic test_random_lines();
    int taken;
    int cmds_start;
    taken = 0;
    cmds_start = cmds_seen + cmd_expected.size();
    while (taken < RANDOM_ITEMS ||
           cmds_seen + cmd_expected.size() - cmds_start < RANDOM_CMDS) begin
      random_line(taken);
    end
  endtask

  initial begin
    clear_line();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_lines();
    test_dropped_bytes();
    test_long_line();
    test_output_hold();
    test_random_lines();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("motor_command_line_parser: match");
    end else begin
      $display("motor_command_line_parser: mismatch");
    end
    $finish;
  end

endmodule
